// ===== sv/dsbp_pkg.sv =====
// dsbp_pkg: shared types and codes of the damped sine burst pair generator
// beat structs, configuration register indexes, controller states, command and status structs
// no dependencies
package dsbp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_US         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_US     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_INTERVAL_US = 3'd6;

    localparam logic [11:0] BASELINE = 12'd2048;

    typedef struct packed {
        logic       mode;
        logic [7:0] velocity;
        logic [7:0] position;
    } in_beat_t;

    typedef struct packed {
        logic [11:0] piezo_a_value;
        logic [11:0] piezo_b_value;
        logic [31:0] timestamp;
        logic        hit_accepted;
        logic        hit_dropped;
        logic [31:0] hits_total;
    } out_beat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BOOK,
        S_AUTO_ARM,
        S_AUTO_CHK,
        S_PICK,
        S_REL,
        S_EMUL,
        S_EIDX,
        S_ELUT,
        S_SLUT,
        S_AMP,
        S_SCALE,
        S_FIN,
        S_ADV,
        S_EXPIRE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_ENV,
        MUL_PHASE,
        MUL_AE,
        MUL_AMP,
        MUL_SCALE
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        logic    book_trig;
        logic    auto_arm;
        logic    auto_check;
        logic    pick;
        logic    rel;
        mul_op_t mul_op;
        logic    env_idx;
        logic    env_lut;
        logic    sine_lut;
        logic    fin;
        logic    chan;
        logic    adv;
        logic    expire;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic none_busy;
        logic skip;
        logic last_slot;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/dsbp_ctrl.sv =====
// dsbp_ctrl: sequencing state machine of the burst pair generator
// drives the datapath command struct from its status struct
// depends on dsbp_pkg
module dsbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 item_mode,
    output logic                 in_stall,
    input  dsbp_pkg::dp_status_t status,
    output dsbp_pkg::dp_cmd_t    cmd
);

    dsbp_pkg::state_t state_reg, state_next;
    logic             chan_reg, chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbp_pkg::S_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            dsbp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = item_mode ? dsbp_pkg::S_BOOK : dsbp_pkg::S_AUTO_ARM;
                end
            end
            dsbp_pkg::S_BOOK:     state_next = dsbp_pkg::S_DONE;
            dsbp_pkg::S_AUTO_ARM: state_next = dsbp_pkg::S_AUTO_CHK;
            dsbp_pkg::S_AUTO_CHK: state_next = dsbp_pkg::S_PICK;
            dsbp_pkg::S_PICK:
            begin
                chan_next  = 1'b0;
                state_next = status.none_busy ? dsbp_pkg::S_ADV : dsbp_pkg::S_REL;
            end
            dsbp_pkg::S_REL:      state_next = dsbp_pkg::S_EMUL;
            dsbp_pkg::S_EMUL:
            begin
                if (status.skip)
                begin
                    chan_next  = 1'b1;
                    state_next = chan_reg ? dsbp_pkg::S_ADV : dsbp_pkg::S_REL;
                end
                else
                begin
                    state_next = dsbp_pkg::S_EIDX;
                end
            end
            dsbp_pkg::S_EIDX:     state_next = dsbp_pkg::S_ELUT;
            dsbp_pkg::S_ELUT:     state_next = dsbp_pkg::S_SLUT;
            dsbp_pkg::S_SLUT:     state_next = dsbp_pkg::S_AMP;
            dsbp_pkg::S_AMP:      state_next = dsbp_pkg::S_SCALE;
            dsbp_pkg::S_SCALE:    state_next = dsbp_pkg::S_FIN;
            dsbp_pkg::S_FIN:
            begin
                chan_next  = 1'b1;
                state_next = chan_reg ? dsbp_pkg::S_ADV : dsbp_pkg::S_REL;
            end
            dsbp_pkg::S_ADV:      state_next = dsbp_pkg::S_EXPIRE;
            dsbp_pkg::S_EXPIRE:
            begin
                if (status.last_slot)
                begin
                    state_next = dsbp_pkg::S_DONE;
                end
            end
            dsbp_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = dsbp_pkg::S_IDLE;
                end
            end
            default:              state_next = dsbp_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = dsbp_pkg::MUL_HOLD;
        cmd.chan   = chan_reg;
        in_stall   = 1'b1;
        case (state_reg)
            dsbp_pkg::S_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            dsbp_pkg::S_BOOK:     cmd.book_trig = 1'b1;
            dsbp_pkg::S_AUTO_ARM: cmd.auto_arm = 1'b1;
            dsbp_pkg::S_AUTO_CHK: cmd.auto_check = 1'b1;
            dsbp_pkg::S_PICK:     cmd.pick = 1'b1;
            dsbp_pkg::S_REL:      cmd.rel = 1'b1;
            dsbp_pkg::S_EMUL:     cmd.mul_op = dsbp_pkg::MUL_ENV;
            dsbp_pkg::S_EIDX:
            begin
                cmd.env_idx = 1'b1;
                cmd.mul_op  = dsbp_pkg::MUL_PHASE;
            end
            dsbp_pkg::S_ELUT:     cmd.env_lut = 1'b1;
            dsbp_pkg::S_SLUT:
            begin
                cmd.sine_lut = 1'b1;
                cmd.mul_op   = dsbp_pkg::MUL_AE;
            end
            dsbp_pkg::S_AMP:      cmd.mul_op = dsbp_pkg::MUL_AMP;
            dsbp_pkg::S_SCALE:    cmd.mul_op = dsbp_pkg::MUL_SCALE;
            dsbp_pkg::S_FIN:      cmd.fin = 1'b1;
            dsbp_pkg::S_ADV:      cmd.adv = 1'b1;
            dsbp_pkg::S_EXPIRE:   cmd.expire = 1'b1;
            dsbp_pkg::S_DONE:     cmd.out_load = status.out_free;
            default:              in_stall = 1'b1;
        endcase
    end

endmodule

// ===== sv/dsbp_datapath.sv =====
// dsbp_datapath: registers, slot pool, shared multiplier, tables and output register
// of the burst pair generator; steered by the command struct of dsbp_ctrl
// depends on dsbp_pkg
module dsbp_datapath #(
    parameter int SLOT_COUNT       = 6,
    parameter int MAX_OFFSET_US    = 1000,
    parameter int TICK_US          = 125,
    parameter int LEAD_US          = 2000,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int EXP_TABLE_DEPTH  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dsbp_pkg::dp_cmd_t                   cmd,
    output dsbp_pkg::dp_status_t                status,
    input  dsbp_pkg::in_beat_t                  in_data,
    input  logic                                cfg_we,
    input  logic [dsbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output dsbp_pkg::out_beat_t                 out_data
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int EIDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [63:0] ONE30       = 64'd1073741824;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] EINV_Q30    = 64'd395007542;

    // table builders, folded at elaboration
    function automatic logic signed [15:0] sine_entry(input int idx);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] sub_acc;
        logic [63:0] r;
        logic        neg;
        th  = (TWO_PI_Q30 * 64'(idx)) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (th > PI_Q30)
        begin
            neg = 1'b1;
            th  = th - PI_Q30;
        end
        if (th > HALF_PI_Q30)
        begin
            th = PI_Q30 - th;
        end
        x2      = (th * th) >> 30;
        term    = th;
        pos     = th;
        sub_acc = 64'd0;
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
            begin
                sub_acc = sub_acc + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        r = (pos > sub_acc) ? pos - sub_acc : 64'd0;
        r = (r * 64'd32767 + (ONE30 >> 1)) >> 30;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return neg ? -16'(r) : 16'(r);
    endfunction

    function automatic logic [16:0] exp_entry(input int idx);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] sub_acc;
        logic [63:0] r;
        y       = ((64'd8 * 64'(idx)) << 30) / 64'(EXP_TABLE_DEPTH);
        n       = y >> 30;
        f       = y & (ONE30 - 64'd1);
        term    = ONE30;
        pos     = ONE30;
        sub_acc = 64'd0;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * f) >> 30) / 64'(k);
            if ((k % 2) == 1)
            begin
                sub_acc = sub_acc + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        r = (pos > sub_acc) ? pos - sub_acc : 64'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (64'(k) < n)
            begin
                r = (r * EINV_Q30) >> 30;
            end
        end
        return 17'((r + 64'd8192) >> 14);
    endfunction

    function automatic logic [15:0] gain_entry(input int vel);
        logic [31:0] g;
        g = (32'd65536 * 32'(vel) + 32'd63) / 32'd127;
        if (g > 32'd32768)
        begin
            g = 32'd32768;
        end
        return 16'(g);
    endfunction

    function automatic logic signed [11:0] offset_entry(input int pos);
        int num;
        int q;
        num = (2 * pos - 127) * MAX_OFFSET_US;
        q   = (num < 0) ? -((-num) / 127) : num / 127;
        return 12'(q);
    endfunction

    localparam logic [15:0]        AUTO_GAIN = gain_entry(100);
    localparam logic signed [11:0] AUTO_OFF  = offset_entry(64);

    logic signed [15:0] sine_tab [SINE_TABLE_DEPTH];
    logic [16:0]        exp_tab  [EXP_TABLE_DEPTH];
    logic [15:0]        gain_tab [128];
    logic signed [11:0] off_tab  [128];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_sine
        assign sine_tab[g] = sine_entry(g);
    end
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_exp
        assign exp_tab[g] = exp_entry(g);
    end
    for (genvar g = 0; g < 128; g++)
    begin : g_hit
        assign gain_tab[g] = gain_entry(g);
        assign off_tab[g]  = offset_entry(g);
    end

    // configuration
    logic [31:0] phase_step_reg;
    logic [15:0] rise_reg;
    logic [23:0] attack_gain_reg;
    logic [23:0] decay_gain_reg;
    logic [19:0] duration_reg;
    logic        auto_en_reg;
    logic [23:0] auto_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= 32'd858993;
            rise_reg          <= 16'd500;
            attack_gain_reg   <= 24'd33554;
            decay_gain_reg    <= 24'd838;
            duration_reg      <= 20'd100000;
            auto_en_reg       <= 1'b0;
            auto_interval_reg <= 24'd500000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsbp_pkg::CFG_PHASE_STEP:       phase_step_reg    <= cfg_data;
                dsbp_pkg::CFG_RISE_US:          rise_reg          <= cfg_data[15:0];
                dsbp_pkg::CFG_ATTACK_GAIN:      attack_gain_reg   <= cfg_data[23:0];
                dsbp_pkg::CFG_DECAY_GAIN:       decay_gain_reg    <= cfg_data[23:0];
                dsbp_pkg::CFG_DURATION_US:      duration_reg      <= cfg_data[19:0];
                dsbp_pkg::CFG_AUTO_ENABLE:      auto_en_reg       <= cfg_data[0];
                dsbp_pkg::CFG_AUTO_INTERVAL_US: auto_interval_reg <= cfg_data[23:0];
                default:                        auto_en_reg       <= auto_en_reg;
            endcase
        end
    end

    // control state of the generator
    logic [39:0]           tl_reg;
    logic [39:0]           nat_reg;
    logic [31:0]           hit_cnt_reg;
    logic [SLOT_COUNT-1:0] busy_reg;

    // slot pool, payload only
    logic [39:0]        slot_start_reg [SLOT_COUNT];
    logic [15:0]        slot_gain_reg  [SLOT_COUNT];
    logic signed [11:0] slot_off_reg   [SLOT_COUNT];

    // per item working registers
    logic [6:0]         vel_reg;
    logic [6:0]         pos_reg;
    logic [31:0]        ts_reg;
    logic               acc_reg;
    logic               drop_reg;
    logic [11:0]        va_reg;
    logic [11:0]        vb_reg;
    logic [SLOT_W-1:0]  slot_idx_reg;
    logic [19:0]        t_reg;
    logic               skip_reg;
    logic               attack_reg;
    logic [51:0]        prod_reg;
    logic [16:0]        env_reg;
    logic               ezero_reg;
    logic [EIDX_W-1:0]  eidx_reg;
    logic [SIDX_W-1:0]  sidx_reg;
    logic signed [15:0] sine_reg;

    logic                out_valid_reg;
    dsbp_pkg::out_beat_t out_data_reg;

    // slot search
    logic [SLOT_W-1:0] free_idx;
    logic              free_any;
    logic [SLOT_W-1:0] hi_idx;

    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        hi_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (busy_reg[i])
            begin
                hi_idx = SLOT_W'(i);
            end
        end
    end

    logic [39:0]        sel_start;
    logic [15:0]        sel_gain;
    logic signed [11:0] sel_off;

    assign sel_start = slot_start_reg[slot_idx_reg];
    assign sel_gain  = slot_gain_reg[slot_idx_reg];
    assign sel_off   = slot_off_reg[slot_idx_reg];

    // booking
    logic               auto_fire;
    logic               book_req;
    logic [39:0]        book_start;
    logic [15:0]        book_gain;
    logic signed [11:0] book_off;

    assign auto_fire = cmd.auto_check && auto_en_reg && (tl_reg >= nat_reg);

    always_comb
    begin
        book_req   = 1'b0;
        book_start = tl_reg + 40'(LEAD_US);
        book_gain  = gain_tab[vel_reg];
        book_off   = off_tab[pos_reg];
        if (cmd.book_trig)
        begin
            book_req = 1'b1;
        end
        else if (auto_fire)
        begin
            book_req   = 1'b1;
            book_start = nat_reg;
            book_gain  = AUTO_GAIN;
            book_off   = AUTO_OFF;
        end
    end

    // time relative to the channel start
    logic signed [41:0] rel;
    logic [41:0]        off_ext;

    assign off_ext = cmd.chan ? {{30{sel_off[11]}}, sel_off} : 42'd0;
    assign rel     = $signed({2'b00, tl_reg} - {2'b00, sel_start} - off_ext);

    // shared multiplier
    logic [31:0] mul_a;
    logic [19:0] mul_b;
    logic [15:0] sine_mag;

    assign sine_mag = sine_reg[15] ? 16'(-sine_reg) : 16'(sine_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            dsbp_pkg::MUL_ENV:
            begin
                if (attack_reg)
                begin
                    mul_a = 32'(attack_gain_reg);
                    mul_b = t_reg;
                end
                else
                begin
                    mul_a = 32'(decay_gain_reg);
                    mul_b = t_reg - 20'(rise_reg);
                end
            end
            dsbp_pkg::MUL_PHASE:
            begin
                mul_a = phase_step_reg;
                mul_b = t_reg;
            end
            dsbp_pkg::MUL_AE:
            begin
                mul_a = 32'(env_reg);
                mul_b = 20'(sel_gain);
            end
            dsbp_pkg::MUL_AMP:
            begin
                mul_a = 32'(prod_reg[31:16]);
                mul_b = 20'(sine_mag);
            end
            dsbp_pkg::MUL_SCALE:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 20'd2047;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic [51:0] prod_next;
    assign prod_next = mul_a * mul_b;

    // table index scaling
    logic [27+EIDX_W:0] eph;
    logic [32+SIDX_W:0] sph;

    assign eph = (28 + EIDX_W)'(prod_reg[26:0]) * (28 + EIDX_W)'(EXP_TABLE_DEPTH);
    assign sph = (33 + SIDX_W)'(prod_reg[31:0]) * (33 + SIDX_W)'(SINE_TABLE_DEPTH);

    // final sample
    logic [41:0]        m_up;
    logic [11:0]        q_val;
    logic signed [13:0] v_raw;
    logic [11:0]        v_clamp;

    assign m_up  = prod_reg[41:0] + 42'(ONE30 - 64'd1);
    assign q_val = sine_reg[15] ? m_up[41:30] : prod_reg[41:30];
    assign v_raw = sine_reg[15] ? 14'sd2048 - $signed({2'b00, q_val})
                                : 14'sd2048 + $signed({2'b00, q_val});

    always_comb
    begin
        if (v_raw < 14'sd0)
        begin
            v_clamp = 12'd0;
        end
        else if (v_raw > 14'sd4095)
        begin
            v_clamp = 12'd4095;
        end
        else
        begin
            v_clamp = v_raw[11:0];
        end
    end

    // expiry check
    logic [11:0] off_mag;
    logic [21:0] lim;
    logic [41:0] end_time;

    assign off_mag  = sel_off[11] ? 12'(-sel_off) : 12'(sel_off);
    assign lim      = 22'(duration_reg) + 22'(off_mag) + 22'(TICK_US);
    assign end_time = 42'(sel_start) + 42'(lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg      <= '0;
            nat_reg     <= '0;
            hit_cnt_reg <= '0;
            busy_reg    <= '0;
        end
        else
        begin
            if (cmd.auto_arm)
            begin
                if (!auto_en_reg)
                begin
                    nat_reg <= '0;
                end
                else if (nat_reg == 40'd0)
                begin
                    nat_reg <= tl_reg + 40'(auto_interval_reg);
                end
            end
            if (auto_fire)
            begin
                nat_reg <= nat_reg + 40'(auto_interval_reg);
            end
            if (book_req && free_any)
            begin
                busy_reg[free_idx] <= 1'b1;
                hit_cnt_reg        <= hit_cnt_reg + 32'd1;
            end
            if (cmd.adv)
            begin
                tl_reg <= tl_reg + 40'(TICK_US);
            end
            if (cmd.expire && busy_reg[slot_idx_reg] && ({2'b00, tl_reg} > end_time))
            begin
                busy_reg[slot_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (book_req && free_any)
        begin
            slot_start_reg[free_idx] <= book_start;
            slot_gain_reg[free_idx]  <= book_gain;
            slot_off_reg[free_idx]   <= book_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 1'b0;
            drop_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            acc_reg  <= 1'b0;
            drop_reg <= 1'b0;
        end
        else if (book_req)
        begin
            acc_reg  <= free_any;
            drop_reg <= !free_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            vel_reg <= (in_data.velocity == 8'd0 || in_data.velocity > 8'd127)
                       ? 7'd100 : in_data.velocity[6:0];
            pos_reg <= (in_data.position > 8'd127) ? 7'd64 : in_data.position[6:0];
            ts_reg  <= tl_reg[31:0];
            va_reg  <= dsbp_pkg::BASELINE;
            vb_reg  <= dsbp_pkg::BASELINE;
        end
        if (cmd.pick)
        begin
            slot_idx_reg <= hi_idx;
        end
        else if (cmd.adv)
        begin
            slot_idx_reg <= '0;
        end
        else if (cmd.expire && slot_idx_reg != LAST_SLOT)
        begin
            slot_idx_reg <= slot_idx_reg + SLOT_W'(1);
        end
        if (cmd.rel)
        begin
            t_reg      <= rel[19:0];
            skip_reg   <= rel[41] || (rel[40:20] != 21'd0) || (rel[19:0] > duration_reg);
            attack_reg <= rel[19:0] < 20'(rise_reg);
        end
        if (cmd.mul_op != dsbp_pkg::MUL_HOLD)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.env_idx)
        begin
            if (attack_reg)
            begin
                env_reg <= (prod_reg[51:8] > 44'd65536) ? 17'd65536 : prod_reg[24:8];
            end
            ezero_reg <= |prod_reg[51:27];
            eidx_reg  <= eph[27 +: EIDX_W];
        end
        if (cmd.env_lut)
        begin
            if (!attack_reg)
            begin
                env_reg <= ezero_reg ? 17'd0 : exp_tab[eidx_reg];
            end
            sidx_reg <= sph[32 +: SIDX_W];
        end
        if (cmd.sine_lut)
        begin
            sine_reg <= sine_tab[sidx_reg];
        end
        if (cmd.fin)
        begin
            if (cmd.chan)
            begin
                vb_reg <= v_clamp;
            end
            else
            begin
                va_reg <= v_clamp;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.piezo_a_value <= va_reg;
            out_data_reg.piezo_b_value <= vb_reg;
            out_data_reg.timestamp     <= ts_reg;
            out_data_reg.hit_accepted  <= acc_reg;
            out_data_reg.hit_dropped   <= drop_reg;
            out_data_reg.hits_total    <= hit_cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.none_busy = (busy_reg == '0);
    assign status.skip      = skip_reg;
    assign status.last_slot = (slot_idx_reg == LAST_SLOT);
    assign status.out_free  = !out_valid_reg || !out_stall;

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg == $past(hit_cnt_reg) || hit_cnt_reg == $past(hit_cnt_reg) + 32'd1)
        else $error("hit counter moved by more than one");

    a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> !acc_reg && !drop_reg)
        else $error("hit flags not cleared on a new item");

    a_tl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.adv |=> $stable(tl_reg))
        else $error("timeline moved outside a tick advance");

    a_busy_set: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.book_trig || cmd.auto_check) |=> (busy_reg & ~$past(busy_reg)) == '0)
        else $error("slot became busy without a booking");

endmodule

// ===== sv/damped_sine_burst_pair_generator.sv =====
// damped_sine_burst_pair_generator: top level of the piezo burst pair generator
// instantiates dsbp_ctrl and dsbp_datapath; depends on dsbp_pkg
//
// Each input beat is either a sample tick (mode 0) or a hit trigger (mode 1), and each
// gives exactly one output beat. A trigger cleans up its velocity and position and books
// a burst into the lowest free slot, starting LEAD_US ahead of the timeline; its output
// beat carries baseline samples plus the accepted or dropped flag. A tick first runs the
// auto hit timer, then computes the channel A and channel B samples of the highest busy
// slot, advances the timeline by TICK_US and sweeps the slots to free expired bursts.
// One beat is worked on at a time. A tick runs longer when both channels are inside their
// burst than when no slot is busy, as the controller steps one shared multiplier through
// eight steps per channel; the expiry sweep checks one slot per cycle. The result sits in
// an output register, so the next beat is taken while a finished result waits on
// out_stall. Configuration writes are taken at any time but must only be made while the
// block is idle.
module damped_sine_burst_pair_generator #(
    parameter int SLOT_COUNT       = 6,
    parameter int MAX_OFFSET_US    = 1000,
    parameter int TICK_US          = 125,
    parameter int LEAD_US          = 2000,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int EXP_TABLE_DEPTH  = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input beats
    input  logic                            in_valid,
    output logic                            in_stall,
    input  dsbp_pkg::in_beat_t              in_data,
    // output beats
    output logic                            out_valid,
    input  logic                            out_stall,
    output dsbp_pkg::out_beat_t             out_data,
    // register writes
    input  logic                            cfg_we,
    input  logic [dsbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsbp_pkg::CFG_DATA_W-1:0] cfg_data
);

    dsbp_pkg::dp_cmd_t    cmd;
    dsbp_pkg::dp_status_t status;

    // sequencer: trigger path books and finishes, tick path runs auto timer,
    // both channel samples, timeline advance and the expiry sweep
    dsbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_mode (in_data.mode),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath state, tables, the shared multiplier and the output register
    dsbp_datapath #(
        .SLOT_COUNT       (SLOT_COUNT),
        .MAX_OFFSET_US    (MAX_OFFSET_US),
        .TICK_US          (TICK_US),
        .LEAD_US          (LEAD_US),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .EXP_TABLE_DEPTH  (EXP_TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
